// ----- hw/rtl/scc_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the SCC block.
package scc_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int FIELD_VERTICES   = 32;
    localparam int VERTEX_W         = 5;
    localparam int COUNT_W          = 6;
    localparam int MODE_W           = 2;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Datapath operation issued by the controller each cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_CLEAR,
        OP_RUN_INIT,
        OP_P1_START,
        OP_P1_STEP,
        OP_POPW,
        OP_P2_INIT,
        OP_P2_POP,
        OP_P2_CHK,
        OP_P2_STEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic n_zero;
        logic start_done;
        logic start_vis;
        logic found;
        logic depth_one;
        logic fc_zero;
        logic chk_vis;
        logic pend_vld;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/scc_datapath.sv -----
// Datapath: adjacency memories, stacks, visited marks and result registers.
module scc_datapath
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [VERTEX_W-1:0] from_vertex,
    input  logic [VERTEX_W-1:0] to_vertex,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VERTEX_W-1:0] vertex,
    output logic                component_end,
    output logic                run_done
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int DW    = $clog2(MAX_VERTICES + 1);
    localparam int LIMIT = (MAX_VERTICES < FIELD_VERTICES) ? MAX_VERTICES : FIELD_VERTICES;

    typedef logic [MAX_VERTICES-1:0] row_t;

    // storage
    row_t             fwd_mem [MAX_VERTICES];
    row_t             rev_mem [MAX_VERTICES];
    logic [AW-1:0]    walk_mem [MAX_VERTICES];
    logic [AW-1:0]    fin_mem  [MAX_VERTICES];

    logic [COUNT_W-1:0] vc_reg;
    row_t               fv_reg, rv_reg, visited_reg;
    logic [DW-1:0]      start_reg, depth_reg, fc_reg;
    logic [AW-1:0]      cur_reg;
    logic               pass2_reg;
    logic [VERTEX_W-1:0] from_reg, to_reg;
    row_t               fwd_rd_reg, rev_rd_reg;
    logic               fwd_vq_reg, rev_vq_reg;
    logic [AW-1:0]      walk_rd_reg, fin_rd_reg;
    logic               pend_vld_reg, pend_cend_reg;
    logic [AW-1:0]      pend_vtx_reg;
    logic               out_valid_reg, out_cend_reg, out_done_reg;
    logic [VERTEX_W-1:0] out_vtx_reg;

    logic [DW-1:0] n_cnt, depth_m1, depth_m2, fc_m1;
    row_t          usable, graph_row, cand;
    logic [AW-1:0] next_vtx, g_addr, fwd_addr, rev_addr;
    logic          found, g_re, produce, load_out, add_ok;
    logic [AW-1:0] prod_vtx;
    op_t           op;

    function automatic logic [AW-1:0] lowest_index(input row_t bits);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = AW'(i);
            end
        end
        return idx;
    endfunction

    assign op = cmd.op;

    // effective vertex count and usable mask
    assign n_cnt = ({1'b0, vc_reg} > 7'(LIMIT)) ? DW'(LIMIT) : DW'(vc_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            usable[i] = (DW'(i) < n_cnt);
        end
    end

    // next unvisited neighbor of the current vertex
    assign graph_row = pass2_reg ? (rev_vq_reg ? rev_rd_reg : '0)
                                 : (fwd_vq_reg ? fwd_rd_reg : '0);
    assign cand     = graph_row & usable & ~visited_reg;
    assign found    = |cand;
    assign next_vtx = lowest_index(cand);
    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign fc_m1    = fc_reg - DW'(1);

    // graph row read address
    always_comb
    begin
        g_addr = next_vtx;
        g_re   = 1'b1;
        unique case (op)
            OP_P1_START: g_addr = start_reg[AW-1:0];
            OP_POPW:     g_addr = walk_rd_reg;
            OP_P2_CHK:   g_addr = fin_rd_reg;
            OP_ADD_RD, OP_P1_STEP, OP_P2_STEP: g_addr = next_vtx;
            default:     g_re = 1'b0;
        endcase
    end

    assign fwd_addr = (op == OP_ADD_RD) ? AW'(from_vertex) : g_addr;
    assign rev_addr = (op == OP_ADD_RD) ? AW'(to_vertex) : g_addr;
    assign add_ok   = (int'(from_reg) < MAX_VERTICES) && (int'(to_reg) < MAX_VERTICES);

    // result production in the second pass
    assign produce  = (op == OP_P2_CHK) || (op == OP_P2_STEP && found);
    assign prod_vtx = (op == OP_P2_CHK) ? fin_rd_reg : next_vtx;
    assign load_out = pend_vld_reg && (produce || op == OP_FINISH);

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        if (g_re) begin
            fwd_rd_reg <= fwd_mem[fwd_addr];
            rev_rd_reg <= rev_mem[rev_addr];
            fwd_vq_reg <= fv_reg[fwd_addr];
            rev_vq_reg <= rv_reg[rev_addr];
        end
        if (op == OP_ADD_RD) begin
            from_reg <= from_vertex;
            to_reg   <= to_vertex;
        end
        if (op == OP_ADD_WR && add_ok) begin
            fwd_mem[AW'(from_reg)] <= (fwd_vq_reg ? fwd_rd_reg : '0) | (row_t'(1) << to_reg);
            rev_mem[AW'(to_reg)]   <= (rev_vq_reg ? rev_rd_reg : '0) | (row_t'(1) << from_reg);
        end
        // walk stack
        if ((op == OP_P1_START && !visited_reg[start_reg[AW-1:0]])) begin
            walk_mem[0] <= start_reg[AW-1:0];
            cur_reg     <= start_reg[AW-1:0];
        end else if (op == OP_P2_CHK) begin
            walk_mem[0] <= fin_rd_reg;
            cur_reg     <= fin_rd_reg;
        end else if ((op == OP_P1_STEP || op == OP_P2_STEP) && found) begin
            walk_mem[depth_reg[AW-1:0]] <= next_vtx;
            cur_reg                     <= next_vtx;
        end else if (op == OP_POPW) begin
            cur_reg <= walk_rd_reg;
        end
        if ((op == OP_P1_STEP || op == OP_P2_STEP) && !found && depth_reg != DW'(1)) begin
            walk_rd_reg <= walk_mem[depth_m2[AW-1:0]];
        end
        // finish order stack
        if (op == OP_P1_STEP && !found) begin
            fin_mem[fc_reg[AW-1:0]] <= cur_reg;
        end
        if (op == OP_P2_POP) begin
            fin_rd_reg <= fin_mem[fc_m1[AW-1:0]];
        end
        if (produce) begin
            pend_vtx_reg <= prod_vtx;
        end
        if (load_out) begin
            out_vtx_reg  <= VERTEX_W'(pend_vtx_reg);
            out_cend_reg <= pend_cend_reg || (op == OP_FINISH);
            out_done_reg <= (op == OP_FINISH);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vc_reg        <= COUNT_W'(FIELD_VERTICES);
            fv_reg        <= '0;
            rv_reg        <= '0;
            visited_reg   <= '0;
            start_reg     <= '0;
            depth_reg     <= '0;
            fc_reg        <= '0;
            pass2_reg     <= 1'b0;
            pend_vld_reg  <= 1'b0;
            pend_cend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                vc_reg <= cfg_data;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                OP_ADD_WR:
                begin
                    if (add_ok) begin
                        fv_reg[AW'(from_reg)] <= 1'b1;
                        rv_reg[AW'(to_reg)]   <= 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    fv_reg <= '0;
                    rv_reg <= '0;
                end
                OP_RUN_INIT:
                begin
                    visited_reg  <= '0;
                    start_reg    <= '0;
                    depth_reg    <= '0;
                    fc_reg       <= '0;
                    pass2_reg    <= 1'b0;
                    pend_vld_reg <= 1'b0;
                end
                OP_P1_START:
                begin
                    if (visited_reg[start_reg[AW-1:0]]) begin
                        start_reg <= start_reg + DW'(1);
                    end else begin
                        visited_reg[start_reg[AW-1:0]] <= 1'b1;
                        depth_reg <= DW'(1);
                    end
                end
                OP_P1_STEP:
                begin
                    if (found) begin
                        visited_reg[next_vtx] <= 1'b1;
                        depth_reg <= depth_reg + DW'(1);
                    end else begin
                        depth_reg <= depth_m1;
                        fc_reg    <= fc_reg + DW'(1);
                        if (depth_reg == DW'(1)) begin
                            start_reg <= start_reg + DW'(1);
                        end
                    end
                end
                OP_P2_INIT:
                begin
                    visited_reg <= '0;
                    pass2_reg   <= 1'b1;
                end
                OP_P2_POP:
                begin
                    fc_reg <= fc_m1;
                end
                OP_P2_CHK:
                begin
                    visited_reg[fin_rd_reg] <= 1'b1;
                    depth_reg     <= DW'(1);
                    pend_vld_reg  <= 1'b1;
                    pend_cend_reg <= 1'b0;
                end
                OP_P2_STEP:
                begin
                    if (found) begin
                        visited_reg[next_vtx] <= 1'b1;
                        depth_reg     <= depth_reg + DW'(1);
                        pend_vld_reg  <= 1'b1;
                        pend_cend_reg <= 1'b0;
                    end else begin
                        depth_reg <= depth_m1;
                        if (depth_reg == DW'(1)) begin
                            pend_cend_reg <= 1'b1;
                        end
                    end
                end
                OP_FINISH:
                begin
                    pend_vld_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // status back to the controller
    always_comb
    begin
        status.n_zero     = (n_cnt == '0);
        status.start_done = (start_reg >= n_cnt);
        status.start_vis  = visited_reg[start_reg[AW-1:0]];
        status.found      = found;
        status.depth_one  = (depth_reg == DW'(1));
        status.fc_zero    = (fc_reg == '0);
        status.chk_vis    = visited_reg[fin_rd_reg];
        status.pend_vld   = pend_vld_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign vertex        = out_vtx_reg;
    assign component_end = out_cend_reg;
    assign run_done      = out_done_reg;

endmodule

// ----- hw/rtl/scc_controller.sv -----
// Controller: sequences edge loading, clearing and the two search passes.
module scc_controller
    import scc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  status_t           status,
    output cmd_t              cmd
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_ADD_WR   = 11'b00000000010,
        ST_P1_START = 11'b00000000100,
        ST_P1_ROW   = 11'b00000001000,
        ST_P1_POPW  = 11'b00000010000,
        ST_P2_INIT  = 11'b00000100000,
        ST_P2_POP   = 11'b00001000000,
        ST_P2_CHK   = 11'b00010000000,
        ST_P2_ROW   = 11'b00100000000,
        ST_P2_POPW  = 11'b01000000000,
        ST_FINISH   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   blocked;

    assign in_ready = (state_reg == ST_IDLE);
    assign blocked  = status.pend_vld && !status.out_free;

    // next state and datapath op
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    priority if (mode == MODE_ADD) begin
                        cmd.op     = OP_ADD_RD;
                        state_next = ST_ADD_WR;
                    end else if (mode == MODE_CLEAR) begin
                        cmd.op = OP_CLEAR;
                    end else if (mode == MODE_RUN && !status.n_zero) begin
                        cmd.op     = OP_RUN_INIT;
                        state_next = ST_P1_START;
                    end else begin
                        // unused mode or empty run: beat taken, nothing to do
                        cmd.op = OP_NONE;
                    end
                end
            end
            ST_ADD_WR:
            begin
                cmd.op     = OP_ADD_WR;
                state_next = ST_IDLE;
            end
            ST_P1_START:
            begin
                if (status.start_done) begin
                    state_next = ST_P2_INIT;
                end else begin
                    cmd.op     = OP_P1_START;
                    state_next = status.start_vis ? ST_P1_START : ST_P1_ROW;
                end
            end
            ST_P1_ROW:
            begin
                cmd.op = OP_P1_STEP;
                priority if (status.found) begin
                    state_next = ST_P1_ROW;
                end else if (status.depth_one) begin
                    state_next = ST_P1_START;
                end else begin
                    state_next = ST_P1_POPW;
                end
            end
            ST_P1_POPW:
            begin
                cmd.op     = OP_POPW;
                state_next = ST_P1_ROW;
            end
            ST_P2_INIT:
            begin
                cmd.op     = OP_P2_INIT;
                state_next = ST_P2_POP;
            end
            ST_P2_POP:
            begin
                if (status.fc_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.op     = OP_P2_POP;
                    state_next = ST_P2_CHK;
                end
            end
            ST_P2_CHK:
            begin
                if (status.chk_vis) begin
                    state_next = ST_P2_POP;
                end else if (!blocked) begin
                    cmd.op     = OP_P2_CHK;
                    state_next = ST_P2_ROW;
                end
            end
            ST_P2_ROW:
            begin
                priority if (status.found) begin
                    if (!blocked) begin
                        cmd.op = OP_P2_STEP;
                    end
                end else if (status.depth_one) begin
                    cmd.op     = OP_P2_STEP;
                    state_next = ST_P2_POP;
                end else begin
                    cmd.op     = OP_P2_STEP;
                    state_next = ST_P2_POPW;
                end
            end
            ST_P2_POPW:
            begin
                cmd.op     = OP_POPW;
                state_next = ST_P2_ROW;
            end
            ST_FINISH:
            begin
                if (!status.pend_vld) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/strongly_connected_components_top.sv -----
// Top level of the strongly connected components block (Kosaraju search).
//
//   channel  dir  handshake            beat
//   in       in   in_valid/in_ready    mode, from_vertex, to_vertex
//   out      out  out_valid/out_ready  vertex, component_end, run_done
//   cfg      in   cfg_we               cfg_data (vertex count)
//
// Add reads a row and then writes it back; clear and unused modes are done in the idle
// state. A run searches the vertices in two passes; a whole adjacency row comes from one
// registered read, so edges are not visited one at a time.
// Reset clears the valid bits of all rows at once; no clearing pass is needed.
// A full output register stalls the second pass; input is taken only when idle.
module strongly_connected_components_top
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [VERTEX_W-1:0] from_vertex,
    input  logic [VERTEX_W-1:0] to_vertex,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VERTEX_W-1:0] vertex,
    output logic                component_end,
    output logic                run_done,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    scc_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    scc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .from_vertex   (from_vertex),
        .to_vertex     (to_vertex),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex        (vertex),
        .component_end (component_end),
        .run_done      (run_done)
    );

endmodule

// ----- tb/strongly_connected_components_top_test.sv -----
// Self-checking testbench for the strongly connected components block.
module strongly_connected_components_top_test;
    import scc_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [VERTEX_W-1:0] from_v;
        logic [VERTEX_W-1:0] to_v;
        int                  cfg;    // -1: plain beat; else vertex count to write first
        bit                  drain;  // wait until all results are in before this beat
    } beat_t;

    typedef struct {
        logic [VERTEX_W-1:0] vertex;
        logic                comp_end;
        logic                done;
    } member_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [MODE_W-1:0] mode;
    logic [VERTEX_W-1:0] from_vertex, to_vertex, vertex;
    logic component_end, run_done;
    logic cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    strongly_connected_components_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .from_vertex(from_vertex), .to_vertex(to_vertex),
        .out_valid(out_valid), .out_ready(out_ready),
        .vertex(vertex), .component_end(component_end), .run_done(run_done),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [31:0] fwd_rows [NV];
    logic [31:0] rev_rows [NV];
    int          model_count;

    beat_t   pending_beats [$];
    member_t expected_members [$];
    int errors = 0;
    int idle_cycles = 0;
    int runs_seen = 0, members_seen = 0;
    bit stim_done = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(0, 3);
    endfunction

    function automatic int lowest(logic [31:0] bits);
        for (int i = 0; i < 32; i++)
            if (bits[i]) return i;
        return 64;
    endfunction

    // append one expected result beat
    function automatic void add_member(logic [VERTEX_W-1:0] v);
        member_t m;
        m.vertex = v;
        m.comp_end = 1'b0;
        m.done = 1'b0;
        expected_members.insert(expected_members.size(), m);
    endfunction

    // append one stimulus beat
    function automatic void add_beat(beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    // Kosaraju prediction for one run; appends the emitted members
    task automatic predict_components();
        int n, fc, depth, v, nx, cnt;
        logic [31:0] usable, seen;
        int order [32];
        int stk [32];
        n = model_count;
        if (n > NV) n = NV;
        if (n > 32) n = 32;
        if (n == 0) return;
        usable = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
        seen = '0;
        fc = 0;
        for (int s = 0; s < n; s++)
        begin
            if (seen[s]) continue;
            seen[s] = 1'b1;
            depth = 0;
            stk[depth++] = s;
            while (depth > 0)
            begin
                v = stk[depth-1];
                nx = lowest(fwd_rows[v] & usable & ~seen);
                if (nx < n && depth < n)
                begin
                    seen[nx] = 1'b1;
                    stk[depth++] = nx;
                end
                else
                begin
                    depth--;
                    if (fc < n) order[fc++] = v;
                end
            end
        end
        seen = '0;
        cnt = 0;
        while (fc > 0)
        begin
            int s;
            s = order[--fc];
            if (seen[s]) continue;
            seen[s] = 1'b1;
            depth = 0;
            stk[depth++] = s;
            add_member(s[4:0]);
            cnt++;
            while (depth > 0)
            begin
                v = stk[depth-1];
                nx = lowest(rev_rows[v] & usable & ~seen);
                if (nx < n && depth < n && cnt < 32)
                begin
                    seen[nx] = 1'b1;
                    stk[depth++] = nx;
                    add_member(nx[4:0]);
                    cnt++;
                end
                else
                    depth--;
            end
            expected_members[$].comp_end = 1'b1;
        end
        expected_members[$].done = 1'b1;
    endtask

    task automatic apply_beat(beat_t b);
        if (b.mode == MODE_ADD)
        begin
            fwd_rows[b.from_v][b.to_v] = 1'b1;
            rev_rows[b.to_v][b.from_v] = 1'b1;
        end
        else if (b.mode == MODE_CLEAR)
        begin
            for (int i = 0; i < NV; i++)
            begin
                fwd_rows[i] = '0;
                rev_rows[i] = '0;
            end
        end
        else if (b.mode == MODE_RUN)
        begin
            runs_seen++;
            predict_components();
        end
    endtask

    function automatic beat_t mk(logic [1:0] m, int f, int t, int c = -1, bit d = 0);
        beat_t b;
        b.mode = m; b.from_v = f[4:0]; b.to_v = t[4:0]; b.cfg = c; b.drain = d;
        return b;
    endfunction

    // Stimulus list
    initial
    begin
        int r;
        // directed: empty graph, extremes, self loops, repeats, mode 3
        add_beat(mk(MODE_RUN, 0, 0));
        add_beat(mk(MODE_ADD, 0, 31));
        add_beat(mk(MODE_ADD, 31, 0));
        add_beat(mk(MODE_ADD, 31, 0));
        add_beat(mk(MODE_ADD, 5, 5));
        add_beat(mk(MODE_ADD, 1, 2));
        add_beat(mk(MODE_ADD, 2, 1));
        add_beat(mk(2'd3, 31, 31));
        add_beat(mk(MODE_RUN, 31, 31));
        add_beat(mk(MODE_RUN, 0, 0, 1, 1));
        add_beat(mk(MODE_RUN, 0, 0, 0, 1));
        add_beat(mk(MODE_ADD, 10, 21, 3, 1));
        add_beat(mk(MODE_RUN, 0, 0));
        add_beat(mk(MODE_CLEAR, 0, 0));
        add_beat(mk(MODE_RUN, 0, 0, 63, 1));
        add_beat(mk(MODE_CLEAR, 0, 0, 32, 1));
        // random phases: a clear, mostly in-range edges with some stray and mode 3 beats, then a run
        while (pending_beats.size() < 215)
        begin
            int ph_n, edges, cfgv;
            cfgv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 10);
            ph_n = (cfgv > 32) ? 32 : (cfgv == 0 ? 1 : cfgv);
            add_beat(mk(MODE_CLEAR, $urandom, $urandom, cfgv, 1));
            edges = $urandom_range(1, 12);
            for (int e = 0; e < edges; e++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    add_beat(mk(2'd3, $urandom, $urandom));
                else if (r == 1)
                    add_beat(mk(MODE_ADD, $urandom, $urandom));
                else
                    add_beat(mk(MODE_ADD, $urandom_range(0, ph_n-1),
                                $urandom_range(0, ph_n-1)));
            end
            add_beat(mk(MODE_RUN, $urandom, $urandom, -1, $urandom_range(0, 3) == 0));
        end
        add_beat(mk(MODE_RUN, 0, 0, 32, 1));
    end

    // Driver
    int send_gap = 0;
    int cfg_hold = 0;
    bit cfg_fire = 0;
    initial
    begin
        rst_n = 0; in_valid = 0; out_ready = 0; mode = '0;
        from_vertex = '0; to_vertex = '0; cfg_we = 0; cfg_data = '0;
        model_count = 32;
        for (int i = 0; i < NV; i++)
        begin
            fwd_rows[i] = '0;
            rev_rows[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cfg_fire = 1'b0;
            if (in_valid && in_ready)
            begin
                apply_beat(pending_beats.pop_front());
                send_gap = pick_gap();
            end
            if (in_valid && !in_ready)
                ; // hold the beat
            else if (pending_beats.size() == 0)
            begin
                in_valid <= 1'b0;
                stim_done = 1;
            end
            else if (pending_beats[0].drain && expected_members.size() != 0)
                in_valid <= 1'b0;
            else if (pending_beats[0].cfg >= 0)
            begin
                // idle long enough for any add still in flight, then write
                in_valid <= 1'b0;
                if (cfg_hold < 8)
                    cfg_hold++;
                else
                begin
                    cfg_fire = 1'b1;
                    cfg_data <= pending_beats[0].cfg[5:0];
                    model_count = pending_beats[0].cfg;
                    pending_beats[0].cfg = -1;
                    cfg_hold = 0;
                end
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else
            begin
                in_valid <= 1'b1;
                mode <= pending_beats[0].mode;
                from_vertex <= pending_beats[0].from_v;
                to_vertex <= pending_beats[0].to_v;
            end
            cfg_we <= cfg_fire;
        end
    end

    // Monitor and sink
    int recv_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                members_seen++;
                if (expected_members.size() == 0)
                begin
                    $error("unexpected result beat: vertex %0d", vertex);
                    errors++;
                end
                else
                begin
                    member_t m;
                    m = expected_members.pop_front();
                    if (vertex !== m.vertex)
                    begin
                        $error("vertex: expected %0d actual %0d", m.vertex, vertex);
                        errors++;
                    end
                    if (component_end !== m.comp_end)
                    begin
                        $error("component_end: expected %0d actual %0d",
                               m.comp_end, component_end);
                        errors++;
                    end
                    if (run_done !== m.done)
                    begin
                        $error("run_done: expected %0d actual %0d", m.done, run_done);
                        errors++;
                    end
                end
                recv_gap = pick_gap();
            end
            if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap--;
            end
            else
                out_ready <= 1'b1;
            // watchdog
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // End of run
    initial
    begin
        int tail;
        tail = 0;
        wait (rst_n);
        while (tail < 300)
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
            if (stim_done && expected_members.size() == 0)
                tail++;
            else
                tail = 0;
        end
        if (expected_members.size() != 0)
            errors++;
        $display("Covered %0d runs with %0d result beats over random graphs,", runs_seen,
                 members_seen);
        $display("vertex counts from 0 to 63, edges out of range, and mode 3.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
